### design/acq_pkg.sv
// Shared types and codes for the actuator command queue.
package acq_pkg;

    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] RES_OK     = 2'd0;
    localparam logic [1:0] RES_QFULL  = 2'd1;
    localparam logic [1:0] RES_NOINIT = 2'd2;
    localparam logic [1:0] RES_REJECT = 2'd3;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_TX   = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    localparam logic [2:0] CMD_QUEUED    = 3'd0;
    localparam logic [2:0] CMD_BAD_SPEED = 3'd1;
    localparam logic [2:0] CMD_ZERO_DUR  = 3'd2;
    localparam logic [2:0] CMD_DISARMED  = 3'd3;
    localparam logic [2:0] CMD_QFULL     = 3'd4;
    localparam logic [2:0] CMD_NONE      = 3'd5;

    localparam logic [2:0] ACK_DONE     = 3'd0;
    localparam logic [2:0] ACK_DEFER    = 3'd1;
    localparam logic [2:0] ACK_REJECTED = 3'd2;
    localparam logic [2:0] ACK_MISMATCH = 3'd3;
    localparam logic [2:0] ACK_NONE     = 3'd4;

    localparam logic signed [15:0] SPEED_MIN = -16'sd16384;
    localparam logic signed [15:0] SPEED_MAX = 16'sd16384;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic latch;
        logic check;
        logic read;
        logic update;
    } t_dp_ctrl;

endpackage

### design/acq_ctrl.sv
// Sequencer that steps one transaction through check, ring read and update.
module acq_ctrl import acq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    output t_dp_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK:  n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy       = 1'b0;
                o_ctrl.latch = i_start;
            end
            ST_CHECK:  o_ctrl.check  = 1'b1;
            ST_READ:   o_ctrl.read   = 1'b1;
            ST_UPDATE: o_ctrl.update = 1'b1;
            default:   o_busy        = 1'b1;
        endcase
    end

endmodule

### design/acq_datapath.sv
// Command ring, pending task registers, ack handling and result registers.
module acq_datapath import acq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_ctrl           i_ctrl,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_opcode,
    input  logic               i_armed,
    input  logic [31:0]        i_now_ms,
    input  logic signed [15:0] i_speed_q,
    input  logic [31:0]        i_duration_in,
    input  logic [31:0]        i_ack_task_id,
    input  logic [1:0]         i_ack_result,
    output logic               o_done,
    output logic [1:0]         o_action,
    output logic [31:0]        o_task_id,
    output logic signed [10:0] o_power,
    output logic [31:0]        o_duration_out,
    output logic [2:0]         o_cmd_status,
    output logic [2:0]         o_ack_status,
    output logic [3:0]         o_ring_fill
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    // latched transaction
    logic [1:0]         r_op;
    logic               r_armed;
    logic [31:0]        r_now;
    logic signed [15:0] r_speed;
    logic [31:0]        r_dur;
    logic [31:0]        r_ack_id;
    logic [1:0]         r_ack_res;

    logic [15:0]        r_timeout;

    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic               r_pv, n_pv;
    logic [31:0]        r_pid, n_pid;
    logic signed [10:0] r_ppow, n_ppow;
    logic [31:0]        r_pdur, n_pdur;
    logic [31:0]        r_next_id, n_next_id;
    logic [31:0]        r_last, n_last;
    logic               r_upd, n_upd;
    logic               r_stop, n_stop;
    logic [2:0]         r_cmd_st, n_cmd_st;
    logic [2:0]         r_ack_st, n_ack_st;
    logic               r_done, n_done;

    logic signed [10:0] r_ring_pow [QUEUE_DEPTH];
    logic [31:0]        r_ring_dur [QUEUE_DEPTH];
    logic signed [10:0] r_rd_pow;
    logic [31:0]        r_rd_dur;

    logic [1:0]         r_out_action, n_out_action;
    logic [31:0]        r_out_tid, n_out_tid;
    logic signed [10:0] r_out_pow, n_out_pow;
    logic [31:0]        r_out_dur, n_out_dur;
    logic [2:0]         r_out_cmd, n_out_cmd;
    logic [2:0]         r_out_ack, n_out_ack;
    logic [3:0]         r_out_qc, n_out_qc;

    logic               w_push;
    logic [15:0]        w_mag;
    logic [20:0]        w_prod;
    logic [10:0]        w_pmag;
    logic signed [10:0] w_pow;
    logic               w_sent;
    logic [31:0]        w_age;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    // rounding half away from zero: (|speed| * 1000 + 8192) >> 14
    always_comb begin
        w_mag  = r_speed[15] ? 16'(-r_speed) : 16'(r_speed);
        w_prod = 21'(w_mag[14:0]) * 21'd125 + 21'd1024;
        w_pmag = {1'b0, w_prod[20:11]};
        w_pow  = r_speed[15] ? -$signed(w_pmag) : $signed(w_pmag);
        w_age  = r_now - r_last;
    end

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_pv         = r_pv;
        n_pid        = r_pid;
        n_ppow       = r_ppow;
        n_pdur       = r_pdur;
        n_next_id    = r_next_id;
        n_last       = r_last;
        n_upd        = r_upd;
        n_stop       = r_stop;
        n_cmd_st     = r_cmd_st;
        n_ack_st     = r_ack_st;
        n_done       = 1'b0;
        n_out_action = r_out_action;
        n_out_tid    = r_out_tid;
        n_out_pow    = r_out_pow;
        n_out_dur    = r_out_dur;
        n_out_cmd    = r_out_cmd;
        n_out_ack    = r_out_ack;
        n_out_qc     = r_out_qc;
        w_push       = 1'b0;
        w_sent       = 1'b0;

        if (i_ctrl.check) begin
            n_upd    = 1'b0;
            n_stop   = 1'b0;
            n_cmd_st = CMD_NONE;
            n_ack_st = ACK_NONE;
            case (r_op) inside
                OP_CMD: begin
                    if (r_speed < SPEED_MIN || r_speed > SPEED_MAX) begin
                        n_cmd_st = CMD_BAD_SPEED;
                    end else if (r_dur == 32'd0) begin
                        n_cmd_st = CMD_ZERO_DUR;
                    end else if (!r_armed) begin
                        n_cmd_st = CMD_DISARMED;
                    end else if (r_count >= FULL_COUNT) begin
                        n_cmd_st = CMD_QFULL;
                    end else begin
                        n_cmd_st = CMD_QUEUED;
                        w_push   = 1'b1;
                        n_tail   = slot_inc(r_tail);
                        n_count  = r_count + CW'(1);
                        n_upd    = 1'b1;
                    end
                end
                OP_ACK, OP_TICK: begin
                    n_upd  = 1'b1;
                    n_stop = !r_armed;
                    if (r_op == OP_ACK) begin
                        if (!r_pv || r_ack_id != r_pid) begin
                            n_ack_st = ACK_MISMATCH;
                        end else begin
                            case (r_ack_res) inside
                                RES_OK: begin
                                    n_pv      = 1'b0;
                                    n_next_id = r_pid + 32'd1;
                                    n_ack_st  = ACK_DONE;
                                end
                                RES_QFULL, RES_NOINIT: begin
                                    n_last   = r_now;
                                    n_ack_st = ACK_DEFER;
                                end
                                default: begin
                                    n_pv     = 1'b0;
                                    n_ack_st = ACK_REJECTED;
                                end
                            endcase
                            if (!n_pv && r_count != '0) begin
                                n_head  = slot_inc(r_head);
                                n_count = r_count - CW'(1);
                            end
                        end
                    end
                    // disarmed with nothing pending: flush the ring
                    if (!r_armed && !n_pv) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_ctrl.update) begin
            if (r_upd && r_armed) begin
                if (!r_pv && r_count != '0) begin
                    n_pid  = r_next_id;
                    n_ppow = r_rd_pow;
                    n_pdur = r_rd_dur;
                    n_pv   = 1'b1;
                    n_last = r_now;
                    w_sent = 1'b1;
                end else if (r_pv && w_age >= {16'd0, r_timeout}) begin
                    n_last = r_now;
                    w_sent = 1'b1;
                end
            end
            n_done       = 1'b1;
            n_out_action = w_sent ? ACT_TX : (r_stop ? ACT_STOP : ACT_NONE);
            n_out_tid    = w_sent ? n_pid : 32'd0;
            n_out_pow    = w_sent ? n_ppow : 11'sd0;
            n_out_dur    = w_sent ? n_pdur : 32'd0;
            n_out_cmd    = r_cmd_st;
            n_out_ack    = r_ack_st;
            n_out_qc     = 4'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_pv      <= 1'b0;
            r_pid     <= '0;
            r_ppow    <= '0;
            r_pdur    <= '0;
            r_next_id <= '0;
            r_last    <= '0;
            r_upd     <= 1'b0;
            r_stop    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_pv      <= n_pv;
            r_pid     <= n_pid;
            r_ppow    <= n_ppow;
            r_pdur    <= n_pdur;
            r_next_id <= n_next_id;
            r_last    <= n_last;
            r_upd     <= n_upd;
            r_stop    <= n_stop;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_op      <= i_opcode;
            r_armed   <= i_armed;
            r_now     <= i_now_ms;
            r_speed   <= i_speed_q;
            r_dur     <= i_duration_in;
            r_ack_id  <= i_ack_task_id;
            r_ack_res <= i_ack_result;
        end
        r_cmd_st     <= n_cmd_st;
        r_ack_st     <= n_ack_st;
        r_out_action <= n_out_action;
        r_out_tid    <= n_out_tid;
        r_out_pow    <= n_out_pow;
        r_out_dur    <= n_out_dur;
        r_out_cmd    <= n_out_cmd;
        r_out_ack    <= n_out_ack;
        r_out_qc     <= n_out_qc;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ring_pow[r_tail] <= w_pow;
            r_ring_dur[r_tail] <= r_dur;
        end
        if (i_ctrl.read) begin
            r_rd_pow <= r_ring_pow[r_head];
            r_rd_dur <= r_ring_dur[r_head];
        end
    end

    assign o_done         = r_done;
    assign o_action       = r_out_action;
    assign o_task_id      = r_out_tid;
    assign o_power        = r_out_pow;
    assign o_duration_out = r_out_dur;
    assign o_cmd_status   = r_out_cmd;
    assign o_ack_status   = r_out_ack;
    assign o_ring_fill    = r_out_qc;

endmodule

### design/actuator_command_queue_arq.sv
// Stop-and-wait sender for timed actuator commands, fed through a command ring.
//
// Input: an item (command, ack or tick) is taken at a clock edge with start
// high and busy low. Each transaction then runs check, ring read and update;
// the ring read uses the memory's single registered read port at the head.
// Result: o_done is high for one cycle, after the check, ring read and update
// states, carrying all result fields. Busy drops in the cycle the result is
// shown, so the next start can be taken while the result is on the ports;
// no new item is taken while busy is high.
// Config: i_cfg_valid/o_cfg_ready write the ack timeout (ms). Ready is
// always high; write only while busy is low.
// Reset (i_rst_n low, synchronous): ring empty, nothing pending, task id
// zero, timeout 1000 ms. Ring contents are not cleared.
// The receiver cannot stall: each result is valid only in its o_done cycle.
module actuator_command_queue_arq import acq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_opcode,
    input  logic               i_armed,
    input  logic [31:0]        i_now_ms,
    input  logic signed [15:0] i_speed_q,
    input  logic [31:0]        i_duration_in,
    input  logic [31:0]        i_ack_task_id,
    input  logic [1:0]         i_ack_result,
    output logic               o_done,
    output logic [1:0]         o_action,
    output logic [31:0]        o_task_id,
    output logic signed [10:0] o_power,
    output logic [31:0]        o_duration_out,
    output logic [2:0]         o_cmd_status,
    output logic [2:0]         o_ack_status,
    output logic [3:0]         o_ring_fill
);

    t_dp_ctrl w_ctrl;

    assign o_cfg_ready = 1'b1;

    acq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctrl  (w_ctrl)
    );

    acq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_armed        (i_armed),
        .i_now_ms       (i_now_ms),
        .i_speed_q      (i_speed_q),
        .i_duration_in  (i_duration_in),
        .i_ack_task_id  (i_ack_task_id),
        .i_ack_result   (i_ack_result),
        .o_done         (o_done),
        .o_action       (o_action),
        .o_task_id      (o_task_id),
        .o_power        (o_power),
        .o_duration_out (o_duration_out),
        .o_cmd_status   (o_cmd_status),
        .o_ack_status   (o_ack_status),
        .o_ring_fill    (o_ring_fill)
    );

endmodule

### design/acq_checker.sv
// Port-level checks for the actuator command queue, bound to the top level.
module acq_checker import acq_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [1:0]         o_action,
    input logic [31:0]        o_task_id,
    input logic signed [10:0] o_power,
    input logic [31:0]        o_duration_out,
    input logic [2:0]         o_cmd_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) && !busy)
        else $error("result without a transaction in progress");

    a_no_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_action != ACT_TX |->
            o_task_id == 32'd0 && o_power == 11'sd0 && o_duration_out == 32'd0)
        else $error("task fields set without a transmission");

    a_stop_not_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_action == ACT_STOP |-> o_cmd_status == CMD_NONE)
        else $error("stop issued on a command transaction");

endmodule

bind actuator_command_queue_arq acq_checker u_acq_checker (.*);
